>>> rtl/bch_pkg.sv
// Package for the BCH(48,30) t=3 decoder: field constants and GF(64) helpers.
// Used by every module of the decoder; depends on nothing.
`default_nettype none
package bch_pkg;
  localparam int CodeLength = 48;
  localparam int DataLength = 30;
  localparam int FieldOrder = 63;
  localparam int NumSyn = 6;
  localparam logic [6:0] PrimPoly = 7'b1011011;

  typedef logic [5:0] gf_t;
  typedef logic [CodeLength-1:0] word_t;

  typedef struct packed {
    logic [29:0] data;
    logic        status;
  } result_t;

  function automatic gf_t gf_mul(input gf_t a, input gf_t b);
    logic [6:0] aa;
    gf_t r;
    r = '0;
    aa = {1'b0, a};
    for (int i = 0; i < 6; i++) begin
      if (b[i]) r = r ^ aa[5:0];
      aa = {aa[5:0], 1'b0};
      if (aa[6]) aa = aa ^ PrimPoly;
    end
    return r;
  endfunction

  function automatic gf_t gf_alpha(input int e);
    gf_t r;
    r = 6'd1;
    for (int i = 0; i < e % FieldOrder; i++) r = gf_mul(r, 6'd2);
    return r;
  endfunction

  // Inverse by search over the powers of alpha: alpha^k maps to alpha^(63-k); zero maps to zero.
  function automatic gf_t gf_inv(input gf_t a);
    gf_t r;
    r = '0;
    for (int k = 0; k < FieldOrder; k++) begin
      if (gf_alpha(k) == a) r = gf_alpha(FieldOrder - k);
    end
    return r;
  endfunction
endpackage
`default_nettype wire

>>> rtl/bch_if.sv
// Valid/ready channel interface carrying one payload word.
// Payload type is given by the instantiating module; no package dependency.
`default_nettype none
interface bch_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/bch_syndrome.sv
// Syndrome unit: S1..S6 of the received word, registered.
// Depends on bch_pkg.
`default_nettype none
module bch_syndrome (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire bch_pkg::word_t        word_i,
  output bch_pkg::gf_t [6:1]         syn_o,
  output bch_pkg::word_t             word_o
);
  bch_pkg::gf_t [6:1] syn_d;

  // Bit at position p (from the x^0 end) contributes alpha^(i*p).
  always_comb begin
    for (int i = 1; i <= 6; i++) begin
      syn_d[i] = '0;
      for (int p = 0; p < bch_pkg::CodeLength; p++) begin
        if (word_i[bch_pkg::CodeLength-1-p]) syn_d[i] = syn_d[i] ^ bch_pkg::gf_alpha(i * p);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      syn_o  <= syn_d;
      word_o <= word_i;
    end
  end
endmodule
`default_nettype wire

>>> rtl/bch_locator.sv
// Error locator unit: closed-form Peterson solution for t=3 over two stages,
// matching the iterative locator for binary codes. Depends on bch_pkg.
`default_nettype none
module bch_locator (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire bch_pkg::gf_t [6:1]    syn_i,
  input  wire bch_pkg::word_t        word_i,
  output bch_pkg::gf_t [3:1]         elp_o,
  output logic [1:0]                 deg_o,
  output logic                       fail_o,
  output logic                       any_o,
  output bch_pkg::word_t             word_o
);
  // Stage A: products. S2 is S1^2 for a binary word.
  bch_pkg::gf_t s1_q, dd_q, num_q;
  logic any_q;
  bch_pkg::word_t word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_q   <= syn_i[1];
      dd_q   <= bch_pkg::gf_mul(syn_i[1], syn_i[2]) ^ syn_i[3];  // S1^3 + S3
      num_q  <= bch_pkg::gf_mul(syn_i[2], syn_i[3]) ^ syn_i[5];  // S1^2 S3 + S5
      any_q  <= |syn_i;
      word_q <= word_i;
    end
  end

  // Stage B: solve. D = S1^3+S3. If D!=0: three-error form, else 1 error, no error or fail.
  bch_pkg::gf_t inv_d;
  bch_pkg::gf_t [3:1] elp_d;
  logic [1:0] deg_d;
  logic fail_d;
  always_comb begin
    inv_d  = bch_pkg::gf_inv(dd_q);
    elp_d  = '0;
    deg_d  = 2'd0;
    fail_d = 1'b0;
    if (dd_q != '0) begin
      // s2 = (S1^2 S3 + S5)/(S1^3+S3), s1 = S1, s3 = S1^3+S3 + S1 s2.
      // This also covers S1=0, and a zero s3 means two errors.
      elp_d[1] = s1_q;
      elp_d[2] = bch_pkg::gf_mul(num_q, inv_d);
      elp_d[3] = dd_q ^ bch_pkg::gf_mul(s1_q, elp_d[2]);
      deg_d    = (elp_d[3] != '0) ? 2'd3 : 2'd2;
    end else if (s1_q != '0) begin
      // Here S3 = S1^3: one error when S5 = S1^5, otherwise more than three.
      elp_d[1] = s1_q;
      deg_d    = 2'd1;
      fail_d   = (num_q != '0);
    end else begin
      fail_d = any_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      elp_o  <= elp_d;
      deg_o  <= deg_d;
      fail_o <= fail_d;
      any_o  <= any_q;
      word_o <= word_q;
    end
  end
endmodule
`default_nettype wire

>>> rtl/bch_chien.sv
// Chien search and correction over all 63 field positions, two stages.
// Depends on bch_pkg.
`default_nettype none
module bch_chien (
  input  wire logic                  clk_i,
  input  wire logic                  en_i,
  input  wire bch_pkg::gf_t [3:1]    elp_i,
  input  wire logic [1:0]            deg_i,
  input  wire logic                  fail_i,
  input  wire logic                  any_i,
  input  wire bch_pkg::word_t        word_i,
  output bch_pkg::result_t           res_o
);
  localparam int Shortened = bch_pkg::FieldOrder - bch_pkg::CodeLength;

  logic [bch_pkg::FieldOrder:1] root_q;
  logic [1:0] deg_q;
  logic fail_q, any_q;
  bch_pkg::word_t word_q;
  logic [bch_pkg::FieldOrder:1] root_d;

  always_comb begin
    for (int i = 1; i <= bch_pkg::FieldOrder; i++) begin
      root_d[i] = ((6'd1 ^ bch_pkg::gf_mul(elp_i[1], bch_pkg::gf_alpha(i))
                   ^ bch_pkg::gf_mul(elp_i[2], bch_pkg::gf_alpha(2 * i))
                   ^ bch_pkg::gf_mul(elp_i[3], bch_pkg::gf_alpha(3 * i))) == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      root_q <= root_d;
      deg_q  <= deg_i;
      fail_q <= fail_i;
      any_q  <= any_i;
      word_q <= word_i;
    end
  end

  // Root alpha^i marks position 63-i; positions 48..62 are shortened away.
  bch_pkg::word_t fix;
  logic bad;
  logic [6:0] cnt;
  logic fail_all;
  always_comb begin
    fix = '0;
    bad = 1'b0;
    for (int i = 1; i <= Shortened; i++) begin
      bad = bad | root_q[i];
    end
    for (int i = Shortened + 1; i <= bch_pkg::FieldOrder; i++) begin
      fix[i - Shortened - 1] = root_q[i];
    end
    cnt = 7'($countones(root_q));
    fail_all = any_q && (fail_q || bad || (cnt != {5'd0, deg_q}));
  end

  bch_pkg::word_t cw;
  assign cw = (any_q && !fail_all) ? (word_q ^ fix) : word_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_o.data   <= cw[bch_pkg::CodeLength-1 -: bch_pkg::DataLength];
      res_o.status <= fail_all;
    end
  end
endmodule
`default_nettype wire

>>> rtl/bch_48_30_t3_decoder.sv
// Top level of the BCH(48,30) t=3 decoder: valid pipeline around three units.
// Depends on bch_pkg, bch_if, bch_syndrome, bch_locator, bch_chien.
//
// Usage:
//   in_i carries one 48-bit received word per handshake; bit 47 is x^0.
//   out_o carries the 30 data bits and a status bit (1 = uncorrectable).
//   There are five register stages: syndromes, two locator stages, root
//   flags, correction. A word can enter every cycle while the last stage
//   is not stalled, so the throughput is then one word per cycle.
//   All stages advance together while the last stage is empty or its word is
//   being taken. While a result waits on the receiver, the whole pipeline
//   holds and in_i.ready drops in the same cycle, so nothing is lost or
//   repeated; empty stages inside the pipeline are not squeezed out.
//   in_i.ready follows out_o.ready combinationally.
//   Reset clears the valid bits of every stage; the data registers are
//   not reset.
`default_nettype none
module bch_48_30_t3_decoder (
  input wire logic clk_i,
  input wire logic rst_ni,
  bch_if.sink      in_i,
  bch_if.source    out_o
);
  localparam int Stages = 5;
  logic [Stages-1:0] vld_q;
  logic en;

  assign en = !vld_q[Stages-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (en) vld_q <= {vld_q[Stages-2:0], in_i.valid};
  end

  bch_pkg::gf_t [6:1] syn;
  bch_pkg::word_t w1, w2;
  bch_pkg::gf_t [3:1] elp;
  logic [1:0] deg;
  logic fail, any;
  bch_pkg::result_t res;

  bch_syndrome u_syn (.clk_i, .en_i(en), .word_i(in_i.data), .syn_o(syn), .word_o(w1));
  bch_locator u_loc (.clk_i, .en_i(en), .syn_i(syn), .word_i(w1), .elp_o(elp),
    .deg_o(deg), .fail_o(fail), .any_o(any), .word_o(w2));
  bch_chien u_chien (.clk_i, .en_i(en), .elp_i(elp), .deg_i(deg), .fail_i(fail),
    .any_i(any), .word_i(w2), .res_o(res));

  assign out_o.valid = vld_q[Stages-1];
  assign out_o.data  = res;
endmodule
`default_nettype wire

>>> rtl/bch_checker.sv
// Port-level checker for the decoder, bound to the top level.
// Depends on bch_pkg and bch_if.
`default_nettype none
module bch_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_ready_i,
  input wire logic             out_valid_i,
  input wire logic             out_ready_i,
  input wire bch_pkg::result_t out_data_i
);
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i) else $error("input stalled with empty output");
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i) else $error("input taken during stall");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(!rst_ni) |-> !out_valid_i) else $error("result right after reset");
endmodule

bind bch_48_30_t3_decoder bch_checker u_chk (
  .clk_i, .rst_ni,
  .in_ready_i(in_i.ready),
  .out_valid_i(out_o.valid), .out_ready_i(out_o.ready), .out_data_i(out_o.data)
);
`default_nettype wire
